/* rtl/voxel_junction_classifier_unit_assert.svh */
// assertion macros used by the checker file
`ifndef VOXEL_JUNCTION_CLASSIFIER_UNIT_ASSERT_SVH
`define VOXEL_JUNCTION_CLASSIFIER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define VJC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define VJC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/vjc_pkg.sv */
// shared types and constants of the voxel junction classifier
`timescale 1ns / 1ps
package vjc_pkg;

  localparam int MAX_ROW     = 256;
  localparam int MAX_ROWS    = 256;
  localparam int MAX_SLICES  = 1024;
  localparam int XW          = $clog2(MAX_ROW);
  localparam int YW          = $clog2(MAX_ROWS);
  localparam int ZW          = 10;
  localparam int WIN_N       = 27;
  localparam int CENTRE_IDX  = 13;
  localparam int QUEUE_DEPTH = 8;
  localparam int CLASS_CAP   = 9;
  // floor(v / 10) as (v * RECIP_10) >> RECIP_SHIFT, exact for 15-bit v
  localparam int RECIP_10    = 52429;
  localparam int RECIP_SHIFT = 19;
  localparam int QW          = 12;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_INSIDE  = 3'd0,
    REG_OUTSIDE = 3'd1,
    REG_HULL    = 3'd2,
    REG_SIZE_X  = 3'd3,
    REG_SIZE_Y  = 3'd4,
    REG_SIZE_Z  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] inside_value;
    logic signed [15:0] outside_value;
    logic [14:0]        hull_threshold;
    logic [8:0]         padded_size_x;
    logic [8:0]         padded_size_y;
    logic [10:0]        padded_size_z;
  } cfg_t;

  // per-item control that rides along the pipeline
  typedef struct packed {
    logic          valid;
    logic          prod;
    logic          last;
    logic [7:0]    pos_x;
    logic [7:0]    pos_y;
    logic [ZW-1:0] pos_z;
  } meta_t;

  typedef logic [WIN_N-1:0][15:0] win_t;

  typedef struct packed {
    logic [7:0]    pos_x;
    logic [7:0]    pos_y;
    logic [ZW-1:0] pos_z;
    logic [4:0]    label_count;
    logic [3:0]    junction_class;
    logic          last_voxel;
  } result_t;

endpackage

/* rtl/vjc_front.sv */
// front end: raster cursor, slice and line stores, 3x3x3 window
`timescale 1ns / 1ps
module vjc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  vjc_pkg::cfg_t      cfg,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] in_voxel_value,
  output logic               acc_prod,
  output vjc_pkg::meta_t     win_meta,
  output vjc_pkg::win_t      win
);
  import vjc_pkg::*;

  logic [XW-1:0] cx_r, cx_nxt, cx_e;
  logic [YW-1:0] cy_r, cy_nxt, cy_e;
  logic [ZW-1:0] cz_r, cz_nxt, cz_e;
  logic [8:0]    px_c, py_c;
  logic [10:0]   pz_c;
  logic [8:0]    x_inc, y_inc;
  logic [10:0]   z_inc;
  logic          accept;
  logic          prod0, last0;

  meta_t         p1_r, p2_r;
  logic signed [15:0] val1_r;
  logic [XW+YW-1:0]   addr1_r;
  logic [XW-1:0]      xaddr1_r;

  logic [31:0]   slice_mem [MAX_ROWS*MAX_ROW];
  logic [95:0]   line_mem  [MAX_ROW];
  logic [31:0]   m_rd_r;
  logic [95:0]   l_rd_r;
  logic [47:0]   col_row0;
  win_t          win_r;

  // sizes held inside their legal range
  always_comb begin
    px_c = (cfg.padded_size_x < 9'd3) ? 9'd3 :
           (cfg.padded_size_x > 9'(MAX_ROW)) ? 9'(MAX_ROW) : cfg.padded_size_x;
    py_c = (cfg.padded_size_y < 9'd3) ? 9'd3 :
           (cfg.padded_size_y > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : cfg.padded_size_y;
    pz_c = (cfg.padded_size_z < 11'd3) ? 11'd3 :
           (cfg.padded_size_z > 11'(MAX_SLICES)) ? 11'(MAX_SLICES) : cfg.padded_size_z;
  end

  // cursor with wrap on a shrunk size, and its advance
  always_comb begin
    cx_e   = ({1'b0, cx_r} >= px_c) ? '0 : cx_r;
    cy_e   = ({1'b0, cy_r} >= py_c) ? '0 : cy_r;
    cz_e   = ({1'b0, cz_r} >= pz_c) ? '0 : cz_r;
    accept = in_valid & ~in_stall;
    prod0  = (cx_e >= XW'(2)) && (cy_e >= YW'(2)) && (cz_e >= ZW'(2));
    last0  = ({1'b0, cx_e} == px_c - 9'd1) && ({1'b0, cy_e} == py_c - 9'd1) &&
             ({1'b0, cz_e} == pz_c - 11'd1);
    x_inc  = {1'b0, cx_e} + 9'd1;
    y_inc  = {1'b0, cy_e} + 9'd1;
    z_inc  = {1'b0, cz_e} + 11'd1;
    cx_nxt = cx_r;
    cy_nxt = cy_r;
    cz_nxt = cz_r;
    if (accept) begin
      cx_nxt = cx_e;
      cy_nxt = cy_e;
      cz_nxt = cz_e;
      if (x_inc >= px_c) begin
        cx_nxt = '0;
        if (y_inc >= py_c) begin
          cy_nxt = '0;
          cz_nxt = (z_inc >= pz_c) ? '0 : z_inc[ZW-1:0];
        end else begin
          cy_nxt = y_inc[YW-1:0];
        end
      end else begin
        cx_nxt = x_inc[XW-1:0];
      end
    end
  end

  assign acc_prod = accept & prod0;

  // cursor registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0;
      cy_r <= '0;
      cz_r <= '0;
    end else begin
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
      cz_r <= cz_nxt;
    end
  end

  // first stage: beat taken, store reads in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r.valid <= 1'b0;
    end else begin
      p1_r.valid <= accept;
    end
    p1_r.prod  <= prod0;
    p1_r.last  <= last0;
    p1_r.pos_x <= cx_e - 8'd2;
    p1_r.pos_y <= cy_e - 8'd2;
    p1_r.pos_z <= cz_e - ZW'(2);
    val1_r     <= in_voxel_value;
    addr1_r    <= {cy_e, cx_e};
    xaddr1_r   <= cx_e;
  end

  // slice store: per (y,x) the two previous slice values
  always_ff @(posedge clk) begin
    m_rd_r <= slice_mem[{cy_e, cx_e}];
    if (p1_r.valid) begin
      slice_mem[addr1_r] <= {val1_r, m_rd_r[31:16]};
    end
  end

  // column of the current row: z, z-1, z-2
  assign col_row0 = {val1_r, m_rd_r};

  // line store: per x the columns of the two rows above
  always_ff @(posedge clk) begin
    l_rd_r <= line_mem[cx_e];
    if (p1_r.valid) begin
      line_mem[xaddr1_r] <= {col_row0, l_rd_r[95:48]};
    end
  end

  // window shift: oldest column out, new column in
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_r.valid <= 1'b0;
    end else begin
      p2_r.valid <= p1_r.valid;
    end
    p2_r.prod  <= p1_r.prod;
    p2_r.last  <= p1_r.last;
    p2_r.pos_x <= p1_r.pos_x;
    p2_r.pos_y <= p1_r.pos_y;
    p2_r.pos_z <= p1_r.pos_z;
    if (p1_r.valid) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i]     <= win_r[i+9];
        win_r[i+9]   <= win_r[i+18];
      end
      // index within a column is row*3 + z, row 0 current, z 0 current
      win_r[18] <= col_row0[47:32];
      win_r[19] <= col_row0[31:16];
      win_r[20] <= col_row0[15:0];
      win_r[21] <= l_rd_r[95:80];
      win_r[22] <= l_rd_r[79:64];
      win_r[23] <= l_rd_r[63:48];
      win_r[24] <= l_rd_r[47:32];
      win_r[25] <= l_rd_r[31:16];
      win_r[26] <= l_rd_r[15:0];
    end
  end

  assign win_meta = p2_r;
  assign win      = win_r;

endmodule

/* rtl/vjc_label.sv */
// label counting: rounding, first-occurrence marks, count and class
`timescale 1ns / 1ps
module vjc_label (
  input  logic              clk,
  input  logic              rst_n,
  input  vjc_pkg::cfg_t     cfg,
  input  vjc_pkg::meta_t    win_meta,
  input  vjc_pkg::win_t     win,
  output logic              push,
  output vjc_pkg::result_t  push_data
);
  import vjc_pkg::*;

  logic [WIN_N-1:0][QW-1:0] q_nxt, q_r;
  logic [WIN_N-1:0]         hit_nxt, hit_r;
  logic [WIN_N-1:0]         first_nxt, first_r;
  logic [30:0]              prod_w [WIN_N];
  logic                     excl_nxt, excl3_r, excl4_r;
  meta_t                    p3_r, p4_r;
  logic [4:0]               cnt;

  // hull hits, centre exclusion, and rounding down to a multiple of ten, kept as the quotient
  always_comb begin
    for (int i = 0; i < WIN_N; i++) begin
      hit_nxt[i] = $signed(win[i]) >= $signed({1'b0, cfg.hull_threshold});
      prod_w[i]  = 31'(win[i][14:0]) * 31'(RECIP_10);
      q_nxt[i]   = prod_w[i][RECIP_SHIFT +: QW];
    end
    excl_nxt = ($signed(win[CENTRE_IDX]) == cfg.inside_value) ||
               ($signed(win[CENTRE_IDX]) == cfg.outside_value);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_r.valid <= 1'b0;
    end else begin
      p3_r.valid <= win_meta.valid;
    end
    p3_r.prod  <= win_meta.prod;
    p3_r.last  <= win_meta.last;
    p3_r.pos_x <= win_meta.pos_x;
    p3_r.pos_y <= win_meta.pos_y;
    p3_r.pos_z <= win_meta.pos_z;
    q_r        <= q_nxt;
    hit_r      <= hit_nxt;
    excl3_r    <= excl_nxt;
  end

  // a label counts once, at its first place in the window
  always_comb begin
    for (int i = 0; i < WIN_N; i++) begin
      first_nxt[i] = hit_r[i];
      for (int j = 0; j < i; j++) begin
        if (hit_r[j] && (q_r[j] == q_r[i])) begin
          first_nxt[i] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_r.valid <= 1'b0;
    end else begin
      p4_r.valid <= p3_r.valid;
    end
    p4_r.prod  <= p3_r.prod;
    p4_r.last  <= p3_r.last;
    p4_r.pos_x <= p3_r.pos_x;
    p4_r.pos_y <= p3_r.pos_y;
    p4_r.pos_z <= p3_r.pos_z;
    first_r    <= first_nxt;
    excl4_r    <= excl3_r;
  end

  // count and class
  always_comb begin
    cnt = excl4_r ? 5'd0 : 5'($countones(first_r));
    push_data.pos_x       = p4_r.pos_x;
    push_data.pos_y       = p4_r.pos_y;
    push_data.pos_z       = p4_r.pos_z;
    push_data.label_count = cnt;
    push_data.last_voxel  = p4_r.last;
    if (cnt < 5'd2) begin
      push_data.junction_class = 4'd0;
    end else if (cnt >= 5'(CLASS_CAP)) begin
      push_data.junction_class = 4'd8;
    end else begin
      push_data.junction_class = 4'(cnt - 5'd1);
    end
  end

  assign push = p4_r.valid & p4_r.prod;

endmodule

/* rtl/vjc_queue.sv */
// result queue between the classifier and the output channel
`timescale 1ns / 1ps
module vjc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  vjc_pkg::result_t  push_data,
  input  logic              pop,
  output logic              not_empty,
  output vjc_pkg::result_t  head
);
  import vjc_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  result_t       q_mem [QUEUE_DEPTH];
  logic [AW-1:0] wr_r, rd_r;
  logic [AW:0]   cnt_r;

  // pointers and fill level; credit upstream keeps pushes within room
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + AW'(1);
      if (pop)  rd_r <= rd_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem[wr_r] <= push_data;
  end

  assign not_empty = (cnt_r != '0);
  assign head      = q_mem[rd_r];

endmodule

/* rtl/voxel_junction_classifier_unit.sv */
// Voxel junction classifier. Takes one padded voxel per cycle unless stalled,
// in raster order (x fastest), and for every interior voxel returns the number
// of distinct surface labels (rounded down to tens) in its 3x3x3 neighbourhood
// and a junction class, registered through the first stage, window shift and
// label stages into the queue; unstalled throughput is one voxel per clock,
// set by the single read and write port of the slice store (two slices deep)
// and the line store (two rows). A small result queue decouples the output;
// input stall rises only when the results in flight would overfill it. No
// clearing pass: a new volume overwrites the stores before they are read.
`timescale 1ns / 1ps
module voxel_junction_classifier_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_voxel_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_pos_x,
  output logic [7:0]         out_pos_y,
  output logic [9:0]         out_pos_z,
  output logic [4:0]         out_label_count,
  output logic [3:0]         out_junction_class,
  output logic               out_last_voxel
);
  import vjc_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH) + 1;

  cfg_t     cfg_r;
  reg_idx_t widx;
  logic     wr_en;
  logic     acc_prod, push, pop, not_empty;
  meta_t    win_meta;
  win_t     win;
  result_t  push_data, head;
  logic [CW-1:0] credit_r;

  // configuration writes
  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inside_value   <= 16'sd0;
      cfg_r.outside_value  <= 16'sd11;
      cfg_r.hull_threshold <= 15'd20;
      cfg_r.padded_size_x  <= 9'd256;
      cfg_r.padded_size_y  <= 9'd256;
      cfg_r.padded_size_z  <= 11'd256;
    end else if (wr_en) begin
      case (widx)
        REG_INSIDE:  cfg_r.inside_value   <= pwdata[15:0];
        REG_OUTSIDE: cfg_r.outside_value  <= pwdata[15:0];
        REG_HULL:    cfg_r.hull_threshold <= pwdata[14:0];
        REG_SIZE_X:  cfg_r.padded_size_x  <= pwdata[8:0];
        REG_SIZE_Y:  cfg_r.padded_size_y  <= pwdata[8:0];
        REG_SIZE_Z:  cfg_r.padded_size_z  <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (widx)
      REG_INSIDE:  prdata = 32'(unsigned'(cfg_r.inside_value));
      REG_OUTSIDE: prdata = 32'(unsigned'(cfg_r.outside_value));
      REG_HULL:    prdata = 32'(cfg_r.hull_threshold);
      REG_SIZE_X:  prdata = 32'(cfg_r.padded_size_x);
      REG_SIZE_Y:  prdata = 32'(cfg_r.padded_size_y);
      REG_SIZE_Z:  prdata = 32'(cfg_r.padded_size_z);
      default:     prdata = 32'd0;
    endcase
  end

  // credit: results in the pipeline plus results queued
  assign pop = not_empty & ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      credit_r <= credit_r + CW'(acc_prod) - CW'(pop);
    end
  end

  assign in_stall = (credit_r >= CW'(QUEUE_DEPTH));

  vjc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_voxel_value (in_voxel_value),
    .acc_prod       (acc_prod),
    .win_meta       (win_meta),
    .win            (win)
  );

  vjc_label u_label (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .win_meta  (win_meta),
    .win       (win),
    .push      (push),
    .push_data (push_data)
  );

  vjc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  assign out_valid          = not_empty;
  assign out_pos_x          = head.pos_x;
  assign out_pos_y          = head.pos_y;
  assign out_pos_z          = head.pos_z;
  assign out_label_count    = head.label_count;
  assign out_junction_class = head.junction_class;
  assign out_last_voxel     = head.last_voxel;

endmodule

/* rtl/vjc_checker.sv */
// port-level checks on the result channel, bound to the top level
`timescale 1ns / 1ps
`include "voxel_junction_classifier_unit_assert.svh"
module vjc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [4:0] out_label_count,
  input logic [3:0] out_junction_class
);

  // a stalled result beat stays offered
  `VJC_ASSERT_NXT(a_hold_valid, out_valid && out_stall, out_valid, "result beat dropped")

  // class follows the label count
  `VJC_ASSERT_IMP(a_class_low, out_valid && (out_label_count < 5'd2), out_junction_class == 4'd0, "class not none")
  `VJC_ASSERT_IMP(a_class_cap, out_valid && (out_label_count >= 5'd9), out_junction_class == 4'd8, "class not capped")
  `VJC_ASSERT_IMP(a_class_mid, out_valid && (out_label_count >= 5'd2) && (out_label_count < 5'd9), out_junction_class == 4'(out_label_count - 5'd1), "class off count")

endmodule

bind voxel_junction_classifier_unit vjc_checker u_vjc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_label_count    (out_label_count),
  .out_junction_class (out_junction_class)
);
